>>> rtl/tlc_pkg.sv
// ----------------------------------------------------------------------------
// tlc_pkg
// shared constants and types of the two-way lru tag lookup unit
// ----------------------------------------------------------------------------
package tlc_pkg;

  // default geometry
  localparam int NUM_SETS_DEF   = 64;
  localparam int LINE_BYTES_DEF = 32;
  localparam int ADDR_BITS_DEF  = 32;

  // fixed field widths
  localparam int ADDR_IN_W = 32;
  localparam int OFFSET_W  = 5;
  localparam int BLOCK_W   = 27;
  localparam int SET_IDX_W = 6;
  localparam int TAG_OUT_W = 21;
  localparam int CNT_W     = 32;

  // way codes
  localparam logic WAY_0 = 1'b0;
  localparam logic WAY_1 = 1'b1;

  // status of one set as seen by the lookup
  typedef struct packed {
    logic valid0;
    logic valid1;
    logic recent;
  } tlc_stat_t;

  // update of one set after a lookup
  typedef struct packed {
    logic en;
    logic way;
  } tlc_upd_t;

  // one result item
  typedef struct packed {
    logic [OFFSET_W-1:0]  byte_offset;
    logic [BLOCK_W-1:0]   block_number;
    logic [SET_IDX_W-1:0] set_index;
    logic                 way;
    logic [TAG_OUT_W-1:0] line_tag;
    logic                 miss;
    logic                 replaced;
    logic [TAG_OUT_W-1:0] evicted_tag;
    logic [CNT_W-1:0]     hit_total;
    logic [CNT_W-1:0]     miss_total;
  } tlc_result_t;

endpackage

>>> rtl/tlc_in_if.sv
// ----------------------------------------------------------------------------
// tlc_in_if
// address channel: valid, ready and one byte address per transfer
// ----------------------------------------------------------------------------
interface tlc_in_if;
  logic                          valid;
  logic                          ready;
  logic [tlc_pkg::ADDR_IN_W-1:0] address;

  modport source (output valid, output address, input ready);
  modport sink (input valid, input address, output ready);
endinterface

>>> rtl/tlc_out_if.sv
// ----------------------------------------------------------------------------
// tlc_out_if
// result channel: valid, ready and the lookup result fields per transfer
// ----------------------------------------------------------------------------
interface tlc_out_if;
  logic                          valid;
  logic                          ready;
  logic [tlc_pkg::OFFSET_W-1:0]  byte_offset;
  logic [tlc_pkg::BLOCK_W-1:0]   block_number;
  logic [tlc_pkg::SET_IDX_W-1:0] set_index;
  logic                          way;
  logic [tlc_pkg::TAG_OUT_W-1:0] line_tag;
  logic                          miss;
  logic                          replaced;
  logic [tlc_pkg::TAG_OUT_W-1:0] evicted_tag;
  logic [tlc_pkg::CNT_W-1:0]     hit_total;
  logic [tlc_pkg::CNT_W-1:0]     miss_total;

  modport source (
    output valid, output byte_offset, output block_number, output set_index,
    output way, output line_tag, output miss, output replaced,
    output evicted_tag, output hit_total, output miss_total, input ready
  );
  modport sink (
    input valid, input byte_offset, input block_number, input set_index,
    input way, input line_tag, input miss, input replaced,
    input evicted_tag, input hit_total, input miss_total, output ready
  );
endinterface

>>> rtl/tlc_ram.sv
// ----------------------------------------------------------------------------
// tlc_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module tlc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/tlc_lru_state.sv
// ----------------------------------------------------------------------------
// tlc_lru_state
// per-set valid bits of both ways and most recently used way bit
// ----------------------------------------------------------------------------
module tlc_lru_state #(
  parameter int NUM_SETS = tlc_pkg::NUM_SETS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [$clog2(NUM_SETS)-1:0] set_i,
  output tlc_pkg::tlc_stat_t          stat_o,
  input  tlc_pkg::tlc_upd_t           upd_i
);

  import tlc_pkg::*;

  logic [NUM_SETS-1:0] valid0_q;
  logic [NUM_SETS-1:0] valid1_q;
  logic [NUM_SETS-1:0] recent_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid0_q <= '0;
      valid1_q <= '0;
      recent_q <= '0;
    end else if (upd_i.en) begin
      if (upd_i.way == WAY_1) begin
        valid1_q[set_i] <= 1'b1;
      end else begin
        valid0_q[set_i] <= 1'b1;
      end
      recent_q[set_i] <= upd_i.way;
    end
  end

  assign stat_o.valid0 = valid0_q[set_i];
  assign stat_o.valid1 = valid1_q[set_i];
  assign stat_o.recent = recent_q[set_i];

endmodule

>>> rtl/two_way_lru_cache_tag_lookup_unit.sv
// ----------------------------------------------------------------------------
// two_way_lru_cache_tag_lookup_unit
// tag store of a two-way set-associative cache with lru replacement
// ----------------------------------------------------------------------------
//  channel  | dir | handshake    | payload
//  ---------+-----+--------------+---------------------------------------------
//  in_i     | in  | valid/ready  | address
//  out_o    | out | valid/ready  | offset, block, set, way, tag, miss,
//           |     |              | replaced, evicted tag, hit/miss totals
//
//  one address per cycle sustained while out does not stall; the input
//  transfer loads the lookup register and the registered tag ram read,
//  which feed the compare, then the result register
//  reset clears valid bits, lru bits and totals at once; no clearing pass
//  a stalled result holds in the result register; the lookup stage holds
//  behind it and input ready drops only when both are full and out stalls
// ----------------------------------------------------------------------------
module two_way_lru_cache_tag_lookup_unit #(
  parameter int NUM_SETS   = tlc_pkg::NUM_SETS_DEF,
  parameter int LINE_BYTES = tlc_pkg::LINE_BYTES_DEF,
  parameter int ADDR_BITS  = tlc_pkg::ADDR_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  tlc_in_if.sink   in_i,
  tlc_out_if.source out_o
);

  import tlc_pkg::*;

  localparam int OFF_W = $clog2(LINE_BYTES);
  localparam int SET_W = $clog2(NUM_SETS);
  // tag keeps at least one bit when offset and set use up the address
  localparam int TAG_W = (ADDR_BITS > OFF_W + SET_W) ? ADDR_BITS - OFF_W - SET_W : 1;
  localparam logic [63:0] ADDR_MASK =
    (ADDR_BITS >= 64) ? '1 : ((64'd1 << ADDR_BITS) - 64'd1);
  localparam logic [63:0] OFF_MASK = 64'(LINE_BYTES - 1);
  localparam logic [63:0] SET_MASK = 64'(NUM_SETS - 1);

  // handshake
  logic in_xfer;
  logic s1_adv;
  logic s1_vld_q;
  logic out_vld_q;

  assign s1_adv  = s1_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !s1_vld_q || s1_adv;
  assign in_xfer = in_i.valid && in_i.ready;

  // set index of the incoming address drives the tag ram read
  logic [63:0]      in_addr64;
  logic [SET_W-1:0] in_set;

  assign in_addr64 = 64'(in_i.address) & ADDR_MASK;
  assign in_set    = in_addr64[OFF_W +: SET_W];

  // lookup register
  logic [ADDR_IN_W-1:0] s1_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_addr_q <= in_i.address;
    end
  end

  // address split of the item in the lookup stage
  logic [63:0]      s1_addr64;
  logic [63:0]      s1_off64;
  logic [63:0]      s1_block64;
  logic [63:0]      s1_set64;
  logic [63:0]      s1_tag64;
  logic [SET_W-1:0] s1_set;
  logic [TAG_W-1:0] s1_tag;

  assign s1_addr64  = 64'(s1_addr_q) & ADDR_MASK;
  assign s1_off64   = s1_addr64 & OFF_MASK;
  assign s1_block64 = s1_addr64 >> OFF_W;
  assign s1_set64   = s1_block64 & SET_MASK;
  assign s1_tag64   = s1_block64 >> SET_W;
  assign s1_set     = s1_set64[SET_W-1:0];
  assign s1_tag     = s1_tag64[TAG_W-1:0];

  // tag rams, one per way
  logic             ram_we0;
  logic             ram_we1;
  logic [TAG_W-1:0] ram_tag0;
  logic [TAG_W-1:0] ram_tag1;

  tlc_ram #(
    .WIDTH (TAG_W),
    .DEPTH (NUM_SETS)
  ) u_tag_ram0 (
    .clk_i   (clk_i),
    .we_i    (ram_we0),
    .waddr_i (s1_set),
    .wdata_i (s1_tag),
    .re_i    (in_xfer),
    .raddr_i (in_set),
    .rdata_o (ram_tag0)
  );

  tlc_ram #(
    .WIDTH (TAG_W),
    .DEPTH (NUM_SETS)
  ) u_tag_ram1 (
    .clk_i   (clk_i),
    .we_i    (ram_we1),
    .waddr_i (s1_set),
    .wdata_i (s1_tag),
    .re_i    (in_xfer),
    .raddr_i (in_set),
    .rdata_o (ram_tag1)
  );

  // last tag written; covers a fill that lands on the edge the next read
  // of the same set is taken, where the ram still returns the old tag
  logic             byp_vld_q;
  logic             byp_way_q;
  logic [SET_W-1:0] byp_set_q;
  logic [TAG_W-1:0] byp_tag_q;

  logic [TAG_W-1:0] tag0;
  logic [TAG_W-1:0] tag1;

  always_comb begin
    tag0 = ram_tag0;
    tag1 = ram_tag1;
    if (byp_vld_q && (byp_set_q == s1_set)) begin
      if (byp_way_q == WAY_1) begin
        tag1 = byp_tag_q;
      end else begin
        tag0 = byp_tag_q;
      end
    end
  end

  // valid and lru bits
  tlc_stat_t stat;
  tlc_upd_t  upd;

  tlc_lru_state #(
    .NUM_SETS (NUM_SETS)
  ) u_lru_state (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .set_i  (s1_set),
    .stat_o (stat),
    .upd_i  (upd)
  );

  // compare both ways, pick the victim on a miss
  logic             hit0;
  logic             hit1;
  logic             hit;
  logic             way;
  logic             evict;
  logic [TAG_W-1:0] old_tag;
  logic [63:0]      old_tag64;

  always_comb begin
    hit0    = stat.valid0 && (tag0 == s1_tag);
    hit1    = stat.valid1 && (tag1 == s1_tag);
    hit     = hit0 || hit1;
    old_tag = '0;
    evict   = 1'b0;
    if (hit) begin
      way = hit0 ? WAY_0 : WAY_1;
    end else begin
      // fill the way that is not most recently used
      way = (stat.recent == WAY_1) ? WAY_0 : WAY_1;
      if (way == WAY_1) begin
        evict = stat.valid1;
        if (stat.valid1) begin
          old_tag = tag1;
        end
      end else begin
        evict = stat.valid0;
        if (stat.valid0) begin
          old_tag = tag0;
        end
      end
    end
  end

  assign old_tag64 = 64'(old_tag);

  assign upd.en  = s1_adv;
  assign upd.way = way;
  assign ram_we0 = s1_adv && !hit && (way == WAY_0);
  assign ram_we1 = s1_adv && !hit && (way == WAY_1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_vld_q <= 1'b0;
    end else if (s1_adv && !hit) begin
      byp_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && !hit) begin
      byp_way_q <= way;
      byp_set_q <= s1_set;
      byp_tag_q <= s1_tag;
    end
  end

  // running totals
  logic [CNT_W-1:0] hit_cnt_q;
  logic [CNT_W-1:0] hit_cnt_d;
  logic [CNT_W-1:0] miss_cnt_q;
  logic [CNT_W-1:0] miss_cnt_d;

  assign hit_cnt_d  = hit ? hit_cnt_q + CNT_W'(1) : hit_cnt_q;
  assign miss_cnt_d = hit ? miss_cnt_q : miss_cnt_q + CNT_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_cnt_q  <= '0;
      miss_cnt_q <= '0;
    end else if (s1_adv) begin
      hit_cnt_q  <= hit_cnt_d;
      miss_cnt_q <= miss_cnt_d;
    end
  end

  // result register
  tlc_result_t res_d;
  tlc_result_t res_q;

  always_comb begin
    res_d.byte_offset  = s1_off64[OFFSET_W-1:0];
    res_d.block_number = s1_block64[BLOCK_W-1:0];
    res_d.set_index    = s1_set64[SET_IDX_W-1:0];
    res_d.way          = way;
    res_d.line_tag     = s1_tag64[TAG_OUT_W-1:0];
    res_d.miss         = !hit;
    res_d.replaced     = evict;
    res_d.evicted_tag  = old_tag64[TAG_OUT_W-1:0];
    res_d.hit_total    = hit_cnt_d;
    res_d.miss_total   = miss_cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (!out_vld_q || out_o.ready) begin
      out_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.byte_offset  = res_q.byte_offset;
  assign out_o.block_number = res_q.block_number;
  assign out_o.set_index    = res_q.set_index;
  assign out_o.way          = res_q.way;
  assign out_o.line_tag     = res_q.line_tag;
  assign out_o.miss         = res_q.miss;
  assign out_o.replaced     = res_q.replaced;
  assign out_o.evicted_tag  = res_q.evicted_tag;
  assign out_o.hit_total    = res_q.hit_total;
  assign out_o.miss_total   = res_q.miss_total;

  // checks
  logic [CNT_W-1:0] ref_total;
  assign ref_total = hit_cnt_q + miss_cnt_q;

  // a set never holds the same tag in both ways
  a_single_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q |-> !(hit0 && hit1))
    else $error("tag matched in both ways of one set");

  // every completed lookup bumps exactly one total
  a_total_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> ref_total == $past(ref_total) + CNT_W'(1))
    else $error("hit and miss totals out of step");

  // an eviction is only reported on a miss
  a_evict_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_o.replaced |-> out_o.miss)
    else $error("eviction reported on a hit");

  // the tag rams are written only on a miss, into one way
  a_fill_one_way: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we0 || ram_we1) |-> (s1_adv && !hit && !(ram_we0 && ram_we1)))
    else $error("tag ram write outside a miss fill");

endmodule
